// ===== rtl/bpv_pkg.sv =====
package bpv_pkg;

    localparam int PROFILE_MAX_DEF   = 1024;
    localparam int ALPHABET_SIZE_DEF = 21;
    localparam int SCORE_BITS_DEF    = 32;
    localparam int TRANS_KINDS       = 7;

    localparam logic [2:0] CMD_START  = 3'd0;
    localparam logic [2:0] CMD_LOAD_M = 3'd1;
    localparam logic [2:0] CMD_LOAD_I = 3'd2;
    localparam logic [2:0] CMD_LOAD_T = 3'd3;
    localparam logic [2:0] CMD_SCORE  = 3'd4;

    localparam logic [1:0] REG_PROFILE_LENGTH  = 2'd0;
    localparam logic [1:0] REG_LOCAL_MODE      = 2'd1;
    localparam logic [1:0] REG_BAND_HALF_WIDTH = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_LOAD,
        ST_SETUP,
        ST_SCORE,
        ST_DRAIN1,
        ST_DRAIN2,
        ST_FINISH
    } bpv_state_t;

    typedef struct packed {
        logic latch;
        logic setup;
        logic load;
        logic clr_issue;
        logic score_issue;
        logic finish;
    } bpv_cmd_t;

    typedef struct packed {
        logic out_free;
    } bpv_stat_t;

endpackage

// ===== rtl/banded_profile_viterbi_column.sv =====
// channel  | ports                                    | direction
// input    | s_valid s_ready s_command s_node_index    | in
//          | s_residue s_transition_kind s_table_value |
// result   | m_valid m_ready m_best_score m_best_node  | out
//          | m_exit_score m_residues_scored m_band_middle |
// config   | APB psel penable pwrite paddr pwdata prdata pready | in
//
// Score residue: accept, setup, PROFILE_MAX+1 node sweep at one node a cycle (set by
// the single read port of each column memory), then states DRAIN1, DRAIN2 and FINISH.
// Start sequence: accept, then PROFILE_MAX+1 column entries cleared, one a cycle.
// Table load: accept, then a load state. Unused commands: accepted and ignored.
// Reset: aresetn synchronous, active low; tables and columns are undefined until
// loaded or a start is issued. A stalled result word holds the block in its finish cycle.
module banded_profile_viterbi_column #(
    parameter int PROFILE_MAX   = bpv_pkg::PROFILE_MAX_DEF,
    parameter int ALPHABET_SIZE = bpv_pkg::ALPHABET_SIZE_DEF,
    parameter int SCORE_BITS    = bpv_pkg::SCORE_BITS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [2:0]         s_command,
    input  logic [10:0]        s_node_index,
    input  logic [4:0]         s_residue,
    input  logic [2:0]         s_transition_kind,
    input  logic signed [31:0] s_table_value,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_best_score,
    output logic [10:0]        m_best_node,
    output logic signed [31:0] m_exit_score,
    output logic [15:0]        m_residues_scored,
    output logic [10:0]        m_band_middle
);
    import bpv_pkg::*;

    localparam int NW = $clog2(PROFILE_MAX + 1);

    logic [10:0]   profile_length_reg;
    logic          local_mode_reg;
    logic [10:0]   band_half_width_reg;
    bpv_cmd_t      cmd;
    bpv_stat_t     stat;
    logic [NW-1:0] k;

    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            profile_length_reg  <= 11'd1;
            local_mode_reg      <= 1'b1;
            band_half_width_reg <= 11'd16;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[3:2])
                REG_PROFILE_LENGTH:  profile_length_reg  <= pwdata[10:0];
                REG_LOCAL_MODE:      local_mode_reg      <= pwdata[0];
                REG_BAND_HALF_WIDTH: band_half_width_reg <= pwdata[10:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_PROFILE_LENGTH:  prdata = 32'(profile_length_reg);
            REG_LOCAL_MODE:      prdata = 32'(local_mode_reg);
            REG_BAND_HALF_WIDTH: prdata = 32'(band_half_width_reg);
            default:             prdata = '0;
        endcase
    end

    bpv_ctrl #(.PROFILE_MAX(PROFILE_MAX)) u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_command(s_command),
        .s_ready(s_ready), .cmd(cmd), .k(k), .stat(stat));

    bpv_datapath #(
        .PROFILE_MAX(PROFILE_MAX), .ALPHABET_SIZE(ALPHABET_SIZE), .SCORE_BITS(SCORE_BITS)
    ) u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .k(k), .stat(stat),
        .s_command(s_command), .s_node_index(s_node_index), .s_residue(s_residue),
        .s_transition_kind(s_transition_kind), .s_table_value(s_table_value),
        .profile_length(profile_length_reg), .local_mode(local_mode_reg),
        .band_half_width(band_half_width_reg),
        .m_valid(m_valid), .m_ready(m_ready), .m_best_score(m_best_score),
        .m_best_node(m_best_node), .m_exit_score(m_exit_score),
        .m_residues_scored(m_residues_scored), .m_band_middle(m_band_middle));
endmodule

// ===== rtl/bpv_ram.sv =====
module bpv_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== rtl/bpv_ctrl.sv =====
module bpv_ctrl #(
    parameter int PROFILE_MAX = 1024
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    input  logic [2:0]                       s_command,
    output logic                             s_ready,
    output bpv_pkg::bpv_cmd_t                cmd,
    output logic [$clog2(PROFILE_MAX+1)-1:0] k,
    input  bpv_pkg::bpv_stat_t               stat
);
    import bpv_pkg::*;

    localparam int NW = $clog2(PROFILE_MAX + 1);

    bpv_state_t    state_reg, state_next;
    logic [NW-1:0] k_reg, k_next;
    logic          last;

    assign last = (k_reg == NW'(PROFILE_MAX));
    assign k    = k_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            k_reg     <= '0;
        end else begin
            state_reg <= state_next;
            k_reg     <= k_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    unique case (s_command)
                        CMD_START:  state_next = ST_CLEAR;
                        CMD_LOAD_M, CMD_LOAD_I, CMD_LOAD_T: state_next = ST_LOAD;
                        CMD_SCORE:  state_next = ST_SETUP;
                        default:    state_next = ST_IDLE;
                    endcase
                end
            end
            ST_CLEAR:  if (last) state_next = ST_IDLE;
            ST_LOAD:   state_next = ST_IDLE;
            ST_SETUP:  state_next = ST_SCORE;
            ST_SCORE:  if (last) state_next = ST_DRAIN1;
            ST_DRAIN1: state_next = ST_DRAIN2;
            ST_DRAIN2: state_next = ST_FINISH;
            ST_FINISH: if (stat.out_free) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        k_next  = '0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready   = 1'b1;
                cmd.latch = s_valid;
            end
            ST_CLEAR: begin
                cmd.clr_issue = 1'b1;
                k_next        = k_reg + 1'b1;
            end
            ST_LOAD:  cmd.load  = 1'b1;
            ST_SETUP: cmd.setup = 1'b1;
            ST_SCORE: begin
                cmd.score_issue = 1'b1;
                k_next          = k_reg + 1'b1;
            end
            ST_DRAIN1, ST_DRAIN2: ;
            ST_FINISH: cmd.finish = stat.out_free;
            default: ;
        endcase
    end
endmodule

// ===== rtl/bpv_datapath.sv =====
module bpv_datapath #(
    parameter int PROFILE_MAX   = 1024,
    parameter int ALPHABET_SIZE = 21,
    parameter int SCORE_BITS    = 32
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  bpv_pkg::bpv_cmd_t                cmd,
    input  logic [$clog2(PROFILE_MAX+1)-1:0] k,
    output bpv_pkg::bpv_stat_t               stat,
    input  logic [2:0]                       s_command,
    input  logic [10:0]                      s_node_index,
    input  logic [4:0]                       s_residue,
    input  logic [2:0]                       s_transition_kind,
    input  logic signed [31:0]               s_table_value,
    input  logic [10:0]                      profile_length,
    input  logic                             local_mode,
    input  logic [10:0]                      band_half_width,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic signed [31:0]               m_best_score,
    output logic [10:0]                      m_best_node,
    output logic signed [31:0]               m_exit_score,
    output logic [15:0]                      m_residues_scored,
    output logic [10:0]                      m_band_middle
);
    import bpv_pkg::*;

    localparam int NODES = PROFILE_MAX + 1;
    localparam int NW    = $clog2(NODES);
    localparam int CAW   = $clog2(2 * NODES);
    localparam int EDEP  = NODES * ALPHABET_SIZE;
    localparam int EAW   = $clog2(EDEP);
    localparam int SB    = SCORE_BITS;

    typedef logic signed [SB-1:0] score_t;

    localparam score_t S_MAX = {1'b0, {(SB-1){1'b1}}};
    localparam score_t S_NEG = {1'b1, {(SB-1){1'b0}}};
    localparam logic signed [63:0] S_MAX64 = 64'(S_MAX);
    localparam logic signed [63:0] S_NEG64 = 64'(S_NEG);
    localparam logic signed [63:0] O_MAX64 = 64'sh7FFF_FFFF;
    localparam logic signed [63:0] O_NEG64 = -64'sh8000_0000;

    function automatic score_t sadd(score_t a, score_t b);
        logic signed [SB:0] s;
        s = {a[SB-1], a} + {b[SB-1], b};
        if (a == S_NEG || b == S_NEG) return S_NEG;
        if (s[SB] != s[SB-1]) return s[SB] ? S_NEG : S_MAX;
        return s[SB-1:0];
    endfunction

    function automatic score_t smax(score_t a, score_t b);
        return (a > b) ? a : b;
    endfunction

    function automatic score_t sat_in(logic signed [31:0] v);
        logic signed [63:0] e;
        e = 64'(v);
        if (e > S_MAX64) return S_MAX;
        if (e < S_NEG64) return S_NEG;
        return SB'(e);
    endfunction

    function automatic logic signed [31:0] sat32(score_t v);
        logic signed [63:0] e;
        e = 64'(v);
        if (e > O_MAX64) return 32'sh7FFF_FFFF;
        if (e < O_NEG64) return 32'sh8000_0000;
        return 32'(e);
    endfunction

    logic [2:0]  cmd_q, kind_q;
    logic [10:0] node_q;
    logic [4:0]  res_q;
    score_t      val_q;

    logic [15:0] count_reg;
    logic [10:0] lbn_reg;
    logic        bank_reg;
    logic        m_valid_reg;

    logic [15:0] kmin_q, kmax_q, center_q;
    logic        prior0_q;
    logic [EAW-1:0] eaddr_q;

    logic        s1_v_q, s2_v_q;
    logic [NW-1:0] k_s1_q, k_s2_q;
    score_t      pm_prev_q, pi_prev_q, pd_prev_q, pm0_q;
    score_t      t_prev_q [5];
    score_t      mt_q, it_q, em_q, iem_q, t3_q, t4_q;
    score_t      mc_q, dc_q, ex_q, best_q;
    logic [10:0] bnode_q;

    score_t      rd_m, rd_i, rd_d, rd_em, rd_iem;
    score_t      t_rd [TRANS_KINDS];

    logic        node_ok, res_ok;
    logic [EAW-1:0] ld_eaddr;
    logic [CAW-1:0] prev_base, cur_base, col_raddr, col_waddr;
    logic        col_we;
    score_t      wm, wi, wd;

    logic [15:0] pl16, lcl, bw16, center_c, kmin_c, kmax_c;
    logic        early;
    logic signed [16:0] lo_c;
    logic [16:0] hi_c;
    logic [4:0]  r_c;

    score_t      mt_c, it_c, m_c, i_c, d_c;
    logic [15:0] k16;
    logic        inband;

    assign node_ok  = 32'(node_q) <= PROFILE_MAX;
    assign res_ok   = 32'(res_q) < ALPHABET_SIZE;
    assign ld_eaddr = EAW'(32'(node_q) * ALPHABET_SIZE + 32'(res_q));

    assign prev_base = bank_reg ? CAW'(NODES) : '0;
    assign cur_base  = bank_reg ? '0 : CAW'(NODES);
    assign col_raddr = prev_base + CAW'(k);

    always_comb begin
        col_we    = cmd.clr_issue | s2_v_q;
        col_waddr = cur_base + CAW'(k_s2_q);
        wm        = m_c;
        wi        = i_c;
        wd        = d_c;
        if (cmd.clr_issue) begin
            col_waddr = prev_base + CAW'(k);
            wm        = (k == '0) ? '0 : S_NEG;
            wi        = S_NEG;
            wd        = S_NEG;
        end
    end

    bpv_ram #(.WIDTH(SB), .DEPTH(2 * NODES)) u_mcol (
        .aclk(aclk), .we(col_we), .waddr(col_waddr), .wdata(wm),
        .raddr(col_raddr), .rdata(rd_m));
    bpv_ram #(.WIDTH(SB), .DEPTH(2 * NODES)) u_icol (
        .aclk(aclk), .we(col_we), .waddr(col_waddr), .wdata(wi),
        .raddr(col_raddr), .rdata(rd_i));
    bpv_ram #(.WIDTH(SB), .DEPTH(2 * NODES)) u_dcol (
        .aclk(aclk), .we(col_we), .waddr(col_waddr), .wdata(wd),
        .raddr(col_raddr), .rdata(rd_d));

    bpv_ram #(.WIDTH(SB), .DEPTH(EDEP)) u_memit (
        .aclk(aclk),
        .we(cmd.load && cmd_q == CMD_LOAD_M && node_ok && res_ok),
        .waddr(ld_eaddr), .wdata(val_q), .raddr(eaddr_q), .rdata(rd_em));
    bpv_ram #(.WIDTH(SB), .DEPTH(EDEP)) u_iemit (
        .aclk(aclk),
        .we(cmd.load && cmd_q == CMD_LOAD_I && node_ok && res_ok),
        .waddr(ld_eaddr), .wdata(val_q), .raddr(eaddr_q), .rdata(rd_iem));

    for (genvar g = 0; g < TRANS_KINDS; g++) begin : g_trans
        bpv_ram #(.WIDTH(SB), .DEPTH(NODES)) u_trans (
            .aclk(aclk),
            .we(cmd.load && cmd_q == CMD_LOAD_T && node_ok && kind_q == 3'(g)),
            .waddr(NW'(node_q)), .wdata(val_q), .raddr(k), .rdata(t_rd[g]));
    end

    // band setup
    always_comb begin
        pl16 = 16'(profile_length);
        bw16 = 16'(band_half_width);
        if (pl16 == '0) begin
            lcl = 16'd1;
        end else if (pl16 > 16'(PROFILE_MAX)) begin
            lcl = 16'(PROFILE_MAX);
        end else begin
            lcl = pl16;
        end
        early    = count_reg < bw16;
        center_c = early ? (lcl >> 1) : (16'(lbn_reg) + 16'd1);
        lo_c     = $signed({1'b0, center_c}) - $signed({1'b0, bw16});
        kmin_c   = early ? 16'd1 : ((lo_c < 17'sd1) ? 16'd1 : lo_c[15:0]);
        hi_c     = {1'b0, center_c} + {1'b0, bw16};
        kmax_c   = early ? lcl : ((hi_c > {1'b0, lcl}) ? lcl : hi_c[15:0]);
        r_c      = (32'(res_q) >= ALPHABET_SIZE) ? 5'(ALPHABET_SIZE - 1) : res_q;
    end

    // stage 1: transitions into node k
    assign mt_c = smax(smax(sadd(pm_prev_q, t_prev_q[0]), sadd(pi_prev_q, t_prev_q[1])),
                       sadd(pd_prev_q, t_prev_q[2]));
    assign it_c = smax(sadd(rd_m, t_rd[5]), sadd(rd_i, t_rd[6]));

    // stage 2: emissions, delete chain
    always_comb begin
        k16    = 16'(k_s2_q);
        inband = (k16 >= kmin_q) && (k16 <= kmax_q);
        m_c    = S_NEG;
        i_c    = S_NEG;
        d_c    = S_NEG;
        if (inband) begin
            m_c = prior0_q ? sadd(pm0_q, em_q) : sadd(mt_q, em_q);
            i_c = sadd(it_q, iem_q);
        end
        if (k16 >= 16'd1 && k16 <= kmax_q) begin
            d_c = smax(sadd(mc_q, t3_q), sadd(dc_q, t4_q));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            lbn_reg     <= '0;
            bank_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
            s1_v_q      <= 1'b0;
            s2_v_q      <= 1'b0;
        end else begin
            s1_v_q <= cmd.score_issue;
            s2_v_q <= s1_v_q;
            if (cmd.latch && s_command == CMD_START) begin
                count_reg <= '0;
                lbn_reg   <= '0;
            end
            if (cmd.finish) begin
                bank_reg    <= ~bank_reg;
                lbn_reg     <= bnode_q;
                m_valid_reg <= 1'b1;
                if (count_reg != 16'hFFFF) begin
                    count_reg <= count_reg + 16'd1;
                end
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.latch) begin
            cmd_q  <= s_command;
            node_q <= s_node_index;
            res_q  <= s_residue;
            kind_q <= s_transition_kind;
            val_q  <= sat_in(s_table_value);
        end
        if (cmd.setup) begin
            kmin_q   <= kmin_c;
            kmax_q   <= kmax_c;
            center_q <= center_c;
            prior0_q <= (count_reg == '0);
            eaddr_q  <= EAW'(r_c);
            ex_q     <= S_NEG;
            best_q   <= S_NEG;
            bnode_q  <= lbn_reg;
        end
        if (cmd.score_issue) begin
            eaddr_q <= eaddr_q + EAW'(ALPHABET_SIZE);
            k_s1_q  <= k;
        end
        if (s1_v_q) begin
            pm_prev_q <= rd_m;
            pi_prev_q <= rd_i;
            pd_prev_q <= rd_d;
            for (int j = 0; j < 5; j++) begin
                t_prev_q[j] <= t_rd[j];
            end
            if (k_s1_q == '0) begin
                pm0_q <= rd_m;
            end
            mt_q   <= mt_c;
            it_q   <= it_c;
            em_q   <= rd_em;
            iem_q  <= rd_iem;
            t3_q   <= t_prev_q[3];
            t4_q   <= t_prev_q[4];
            k_s2_q <= k_s1_q;
        end
        if (s2_v_q) begin
            mc_q <= m_c;
            dc_q <= d_c;
            if (local_mode) begin
                ex_q <= smax(ex_q, m_c);
            end
            if (m_c > best_q) begin
                best_q  <= m_c;
                bnode_q <= 11'(k_s2_q);
            end
        end
        if (cmd.finish) begin
            m_best_score      <= sat32(smax(best_q, ex_q));
            m_best_node       <= bnode_q;
            m_exit_score      <= sat32(ex_q);
            m_residues_scored <= (count_reg != 16'hFFFF) ? count_reg + 16'd1 : count_reg;
            m_band_middle     <= center_q[10:0];
        end
    end

    assign m_valid       = m_valid_reg;
    assign stat.out_free = !m_valid_reg || m_ready;
endmodule
